// ----- hdl/dtp_pkg.sv -----
// shared constants and register codes for the disparity to point unit
package dtp_pkg;

    localparam int DISP_W   = 8;
    localparam int PIX_W    = 12;
    localparam int DIFF_W   = 13;
    localparam int Z_W      = 24;
    localparam int FOCAL_W  = 16;
    localparam int DIM_W    = 13;
    localparam int XY_W     = 36;
    localparam int PROD_W   = 38;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam int COORD_BITS_DEF = 12;

    localparam logic [Z_W-1:0]     DEPTH_NUM_RST    = 24'd243613;
    localparam logic [FOCAL_W-1:0] FOCAL_PX_RST     = 16'd1392;
    localparam logic [DIM_W-1:0]   IMAGE_WIDTH_RST  = 13'd1024;
    localparam logic [DIM_W-1:0]   IMAGE_HEIGHT_RST = 13'd512;

    localparam logic [XY_W-1:0] XY_POS_MAX = {1'b0, {(XY_W-1){1'b1}}};
    localparam logic [XY_W-1:0] XY_NEG_MIN = {1'b1, {(XY_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEPTH_NUM    = 8'd0,
        REG_FOCAL_PX     = 8'd1,
        REG_IMAGE_WIDTH  = 8'd2,
        REG_IMAGE_HEIGHT = 8'd3
    } reg_idx_t;

endpackage

// ----- hdl/disparity_to_point_unit.sv -----
// disparity to 3d point reprojection, top level
//
// input channel s_*: one pixel request per cycle while s_ready is high (disparity, row, column)
// output channel m_*: one point per request, in request order
// config channel cfg_*: register index and data, always ready, write only
//   while no request is in flight
// pipeline: input register, 24 stages of a one-bit-per-stage divider for
//   depth, a multiply stage, a magnitude stage, 36 stages of a pair of
//   one-bit-per-stage dividers by the focal length, output register
// the path from input to output holds 64 register stages
// throughput is one point per cycle while the receiver takes every point, set by the fully pipelined dividers
// the whole pipeline advances when the output register is empty or taken,
//   so a stalled receiver holds every stage and s_ready drops with it
// reset clears all valid bits and loads the register defaults
// zero disparity yields point_valid low and zero coordinates
module disparity_to_point_unit
    import dtp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [DISP_W-1:0]       s_disparity,
    input  logic [PIX_W-1:0]        s_pixel_row,
    input  logic [PIX_W-1:0]        s_pixel_col,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [XY_W-1:0]  m_point_x,
    output logic signed [XY_W-1:0]  m_point_y,
    output logic [Z_W-1:0]          m_point_z,
    output logic                    m_point_valid,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam logic [PIX_W-1:0] CMASK =
        (COORD_BITS >= PIX_W) ? {PIX_W{1'b1}} : PIX_W'((1 << COORD_BITS) - 1);

    // configuration registers
    logic [Z_W-1:0]     depth_num_reg;
    logic [FOCAL_W-1:0] focal_px_reg;
    logic [DIM_W-1:0]   image_width_reg;
    logic [DIM_W-1:0]   image_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_num_reg    <= DEPTH_NUM_RST;
            focal_px_reg     <= FOCAL_PX_RST;
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_DEPTH_NUM:    depth_num_reg    <= cfg_data[Z_W-1:0];
                REG_FOCAL_PX:     focal_px_reg     <= cfg_data[FOCAL_W-1:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    logic [FOCAL_W-1:0] focal_div;
    assign focal_div = (focal_px_reg == '0) ? FOCAL_W'(1) : focal_px_reg;

    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // input stage and depth divider
    logic                    zv_reg  [0:Z_W];
    logic [Z_W-1:0]          zn_reg  [0:Z_W];
    logic [DISP_W-1:0]       zr_reg  [0:Z_W];
    logic [Z_W-1:0]          zq_reg  [0:Z_W];
    logic [DISP_W-1:0]       zd_reg  [0:Z_W];
    logic signed [DIFF_W-1:0] zdx_reg [0:Z_W];
    logic signed [DIFF_W-1:0] zdy_reg [0:Z_W];
    logic                    zz_reg  [0:Z_W];

    logic [PIX_W-1:0] col_m, row_m;
    assign col_m = s_pixel_col & CMASK;
    assign row_m = s_pixel_row & CMASK;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zv_reg[0] <= 1'b0;
        end else if (adv) begin
            zv_reg[0] <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            zn_reg[0]  <= depth_num_reg;
            zr_reg[0]  <= '0;
            zq_reg[0]  <= '0;
            zd_reg[0]  <= (s_disparity == '0) ? DISP_W'(1) : s_disparity;
            zz_reg[0]  <= (s_disparity == '0);
            zdx_reg[0] <= $signed({1'b0, col_m}) - $signed({1'b0, image_width_reg[DIM_W-1:1]});
            zdy_reg[0] <= $signed({1'b0, row_m}) - $signed({1'b0, image_height_reg[DIM_W-1:1]});
        end
    end

    for (genvar k = 0; k < Z_W; k++) begin : g_zdiv
        logic [DISP_W:0] trial;
        logic            ge;
        assign trial = {zr_reg[k], zn_reg[k][Z_W-1-k]};
        assign ge    = trial >= {1'b0, zd_reg[k]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                zv_reg[k+1] <= 1'b0;
            end else if (adv) begin
                zv_reg[k+1] <= zv_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                zr_reg[k+1]  <= ge ? DISP_W'(trial - {1'b0, zd_reg[k]}) : trial[DISP_W-1:0];
                zq_reg[k+1]  <= {zq_reg[k][Z_W-2:0], ge};
                zn_reg[k+1]  <= zn_reg[k];
                zd_reg[k+1]  <= zd_reg[k];
                zz_reg[k+1]  <= zz_reg[k];
                zdx_reg[k+1] <= zdx_reg[k];
                zdy_reg[k+1] <= zdy_reg[k];
            end
        end
    end

    // multiply stage
    logic                     mv_reg;
    logic signed [PROD_W-1:0] mpx_reg, mpy_reg;
    logic [Z_W-1:0]           mz_reg;
    logic                     mzero_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (adv) begin
            mv_reg <= zv_reg[Z_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mpx_reg   <= zdx_reg[Z_W] * $signed({1'b0, zq_reg[Z_W]});
            mpy_reg   <= zdy_reg[Z_W] * $signed({1'b0, zq_reg[Z_W]});
            mz_reg    <= zq_reg[Z_W];
            mzero_reg <= zz_reg[Z_W];
        end
    end

    // magnitude stage and lateral dividers
    logic                xv_reg  [0:XY_W];
    logic [XY_W-1:0]     xn_reg  [0:XY_W];
    logic [FOCAL_W-1:0]  xr_reg  [0:XY_W];
    logic [XY_W-1:0]     xq_reg  [0:XY_W];
    logic [XY_W-1:0]     yn_reg  [0:XY_W];
    logic [FOCAL_W-1:0]  yr_reg  [0:XY_W];
    logic [XY_W-1:0]     yq_reg  [0:XY_W];
    logic                xs_reg  [0:XY_W];
    logic                ys_reg  [0:XY_W];
    logic [Z_W-1:0]      xz_reg  [0:XY_W];
    logic                xzero_reg [0:XY_W];

    logic [PROD_W-1:0] absx, absy;
    assign absx = mpx_reg[PROD_W-1] ? PROD_W'(-mpx_reg) : mpx_reg;
    assign absy = mpy_reg[PROD_W-1] ? PROD_W'(-mpy_reg) : mpy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xv_reg[0] <= 1'b0;
        end else if (adv) begin
            xv_reg[0] <= mv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            xn_reg[0]    <= absx[XY_W-1:0];
            yn_reg[0]    <= absy[XY_W-1:0];
            xr_reg[0]    <= '0;
            yr_reg[0]    <= '0;
            xq_reg[0]    <= '0;
            yq_reg[0]    <= '0;
            xs_reg[0]    <= mpx_reg[PROD_W-1];
            ys_reg[0]    <= mpy_reg[PROD_W-1];
            xz_reg[0]    <= mz_reg;
            xzero_reg[0] <= mzero_reg;
        end
    end

    for (genvar k = 0; k < XY_W; k++) begin : g_xydiv
        logic [FOCAL_W:0] trx, try_v;
        logic             gex, gey;
        assign trx   = {xr_reg[k], xn_reg[k][XY_W-1-k]};
        assign try_v = {yr_reg[k], yn_reg[k][XY_W-1-k]};
        assign gex   = trx >= {1'b0, focal_div};
        assign gey   = try_v >= {1'b0, focal_div};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                xv_reg[k+1] <= 1'b0;
            end else if (adv) begin
                xv_reg[k+1] <= xv_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                xr_reg[k+1]    <= gex ? FOCAL_W'(trx - {1'b0, focal_div}) : trx[FOCAL_W-1:0];
                yr_reg[k+1]    <= gey ? FOCAL_W'(try_v - {1'b0, focal_div})
                                      : try_v[FOCAL_W-1:0];
                xq_reg[k+1]    <= {xq_reg[k][XY_W-2:0], gex};
                yq_reg[k+1]    <= {yq_reg[k][XY_W-2:0], gey};
                xn_reg[k+1]    <= xn_reg[k];
                yn_reg[k+1]    <= yn_reg[k];
                xs_reg[k+1]    <= xs_reg[k];
                ys_reg[k+1]    <= ys_reg[k];
                xz_reg[k+1]    <= xz_reg[k];
                xzero_reg[k+1] <= xzero_reg[k];
            end
        end
    end

    // saturate, sign and output register
    logic [XY_W-1:0] qx, qy, rx, ry;
    assign qx = xq_reg[XY_W];
    assign qy = yq_reg[XY_W];

    always_comb begin
        if (!xs_reg[XY_W]) begin
            rx = (qx > XY_POS_MAX) ? XY_POS_MAX : qx;
        end else begin
            rx = (qx > XY_NEG_MIN) ? XY_NEG_MIN : XY_W'(-qx);
        end
        if (!ys_reg[XY_W]) begin
            ry = (qy > XY_POS_MAX) ? XY_POS_MAX : qy;
        end else begin
            ry = (qy > XY_NEG_MIN) ? XY_NEG_MIN : XY_W'(-qy);
        end
    end

    logic out_vld_reg;
    assign m_valid = out_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= xv_reg[XY_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_point_x     <= xzero_reg[XY_W] ? '0 : $signed(rx);
            m_point_y     <= xzero_reg[XY_W] ? '0 : $signed(ry);
            m_point_z     <= xzero_reg[XY_W] ? '0 : xz_reg[XY_W];
            m_point_valid <= !xzero_reg[XY_W];
        end
    end

endmodule
